// ===== design/alu_8bit_two_nibble_slices_defines.svh =====
// Assertion macros used by the checker file of the two-slice ALU.
`ifndef ALU_8BIT_TWO_NIBBLE_SLICES_DEFINES_SVH
`define ALU_8BIT_TWO_NIBBLE_SLICES_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define ALU8S_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define ALU8S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/alu8s_pkg.sv =====
// Types and constants of the two-slice eight-bit ALU.
package alu8s_pkg;

  localparam int unsigned NibW  = 4;
  localparam int unsigned DataW = 2 * NibW;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_NEG  = 4'd2,
    OP_SHL  = 4'd3,
    OP_SHLC = 4'd4,
    OP_INC  = 4'd5,
    OP_ADC  = 4'd6,
    OP_SBC  = 4'd7,
    OP_NOT  = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_XOR  = 4'd11,
    OP_ZERO = 4'd12,
    OP_TEST = 4'd13,
    OP_SHR  = 4'd14,
    OP_SHRC = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [NibW-1:0] nibble;
    logic            carry;
    logic            overflow;
  } slice_out_t;

endpackage

// ===== design/alu8s_slice.sv =====
// One four-bit ALU slice: nibble result, slice carry and overflow.
module alu8s_slice (
  input  logic [alu8s_pkg::NibW-1:0] a,
  input  logic [alu8s_pkg::NibW-1:0] b,
  input  alu8s_pkg::opcode_t         op,
  input  logic                       c,
  input  logic                       low_slice,
  output alu8s_pkg::slice_out_t      y
);
  import alu8s_pkg::*;

  logic [NibW:0] r;
  logic [NibW:0] addend;
  logic          of;
  logic          fixed;
  logic          cv;
  logic          inc_v;
  logic          a_nz;

  // The low slice uses a fixed carry except for the carry-through variants.
  assign fixed = low_slice && (op != OP_ADC) && (op != OP_SBC) && (op != OP_SHLC);
  assign cv    = fixed ? 1'b0 : c;
  assign inc_v = fixed | c;
  assign a_nz  = (a != '0);

  always_comb begin
    r      = '0;
    addend = '0;
    of     = 1'b0;
    unique case (op)
      OP_ADD, OP_ADC: begin
        addend = {1'b0, b};
        r      = {1'b0, a} + addend + {{NibW{1'b0}}, cv};
        of     = (a[NibW-1] == addend[NibW-1]) && (a[NibW-1] != r[NibW-1]);
      end
      OP_SUB, OP_SBC: begin
        addend = {1'b1, ~b} + {{NibW{1'b0}}, 1'b1} - {{NibW{1'b0}}, cv};
        r      = {1'b0, a} + addend;
        of     = (a[NibW-1] == addend[NibW-1]) && (a[NibW-1] != r[NibW-1]);
      end
      OP_NEG: begin
        r = ({1'b1, ~a} + {{NibW{1'b0}}, inc_v}) ^ {1'b1, {NibW{1'b0}}};
      end
      OP_SHL, OP_SHLC: begin
        r = {a, cv};
      end
      OP_INC: begin
        r  = {1'b0, a} + {{NibW{1'b0}}, inc_v};
        of = !a[NibW-1] && r[NibW-1];
      end
      OP_NOT:  r = {1'b1, ~a};
      OP_AND:  r = {1'b0, a & b};
      OP_OR:   r = {1'b0, a | b};
      OP_XOR:  r = {1'b0, a ^ b};
      OP_ZERO: r = '0;
      OP_TEST: begin
        if (low_slice) begin
          r = {{NibW{1'b0}}, a_nz | c};
        end else begin
          r = {a_nz, {NibW{1'b0}}};
        end
      end
      OP_SHR:  r = {a[0], low_slice & c, a[NibW-1:1]};
      OP_SHRC: r = {a[0], c, a[NibW-1:1]};
      default: r = '0;
    endcase
  end

  assign y.nibble   = r[NibW-1:0];
  assign y.carry    = r[NibW];
  assign y.overflow = of;

endmodule

// ===== design/alu8s_datapath.sv =====
// Two slices chained in the order that the opcode selects.
module alu8s_datapath (
  input  logic [alu8s_pkg::DataW-1:0] a,
  input  logic [alu8s_pkg::DataW-1:0] b,
  input  alu8s_pkg::opcode_t          op,
  input  logic                        cin,
  output alu8s_pkg::slice_out_t       lo,
  output alu8s_pkg::slice_out_t       hi
);
  import alu8s_pkg::*;

  logic            hi_first;
  logic [NibW-1:0] first_a;
  logic [NibW-1:0] first_b;
  logic [NibW-1:0] second_a;
  logic [NibW-1:0] second_b;
  slice_out_t      first_y;
  slice_out_t      second_y;

  // Logic and shift-right opcodes run the high slice first.
  assign hi_first = op[NibW-1];
  assign first_a  = hi_first ? a[DataW-1:NibW] : a[NibW-1:0];
  assign first_b  = hi_first ? b[DataW-1:NibW] : b[NibW-1:0];
  assign second_a = hi_first ? a[NibW-1:0] : a[DataW-1:NibW];
  assign second_b = hi_first ? b[NibW-1:0] : b[DataW-1:NibW];

  alu8s_slice u_first (
    .a         (first_a),
    .b         (first_b),
    .op        (op),
    .c         (cin),
    .low_slice (!hi_first),
    .y         (first_y)
  );

  alu8s_slice u_second (
    .a         (second_a),
    .b         (second_b),
    .op        (op),
    .c         (first_y.carry),
    .low_slice (hi_first),
    .y         (second_y)
  );

  assign lo = hi_first ? second_y : first_y;
  assign hi = hi_first ? first_y : second_y;

endmodule

// ===== design/alu_8bit_two_nibble_slices.sv =====
// Top level of the eight-bit ALU built from two four-bit slices.
//
//   Channel   Direction  Transfer                 Ports
//   command   in         start && !busy at edge   operand_a operand_b opcode carry
//   result    out        done at edge             result, high_* and low_* flags
//
// A command is registered at the edge that takes it, and the slices work on the
// registered operands.
// The result register loads at the next edge, so done is high for exactly one
// cycle; a command passes the input register and then the result register.
// A new command is taken in every cycle; busy stays low and the receiver cannot
// hold results off.
// rst clears the valid bits of the input and result registers.
module alu_8bit_two_nibble_slices (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [alu8s_pkg::DataW-1:0] operand_a,
  input  logic [alu8s_pkg::DataW-1:0] operand_b,
  input  logic [alu8s_pkg::NibW-1:0]  opcode,
  input  logic                        carry,
  output logic                        done,
  output logic [alu8s_pkg::DataW-1:0] result,
  output logic                        high_carry,
  output logic                        high_zero,
  output logic                        high_sign,
  output logic                        high_overflow,
  output logic                        low_carry,
  output logic                        low_zero,
  output logic                        low_sign,
  output logic                        low_overflow
);
  import alu8s_pkg::*;

  logic             in_valid;
  logic [DataW-1:0] in_a;
  logic [DataW-1:0] in_b;
  opcode_t          in_op;
  logic             in_cin;
  slice_out_t       lo;
  slice_out_t       hi;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_a   <= operand_a;
      in_b   <= operand_b;
      in_op  <= opcode_t'(opcode);
      in_cin <= carry;
    end
  end

  alu8s_datapath u_datapath (
    .a   (in_a),
    .b   (in_b),
    .op  (in_op),
    .cin (in_cin),
    .lo  (lo),
    .hi  (hi)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result        <= {hi.nibble, lo.nibble};
      high_carry    <= hi.carry;
      high_zero     <= (hi.nibble == '0);
      high_sign     <= hi.nibble[NibW-1];
      high_overflow <= hi.overflow;
      low_carry     <= lo.carry;
      low_zero      <= (lo.nibble == '0);
      low_sign      <= lo.nibble[NibW-1];
      low_overflow  <= lo.overflow;
    end
  end

endmodule

// ===== design/alu8s_checker.sv =====
// Port-level checks of the two-slice ALU, bound to the top level.
`include "alu_8bit_two_nibble_slices_defines.svh"

module alu8s_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [alu8s_pkg::NibW-1:0]  opcode,
  input logic                        done,
  input logic [alu8s_pkg::DataW-1:0] result,
  input logic                        high_zero,
  input logic                        high_sign,
  input logic                        high_overflow,
  input logic                        low_zero,
  input logic                        low_sign,
  input logic                        low_overflow
);
  import alu8s_pkg::*;

  logic cmd_xfer;
  logic op_msb;
  logic any_ovf;
  logic flags_ok;

  assign cmd_xfer = start && !busy;
  assign op_msb   = opcode[NibW-1];
  assign any_ovf  = high_overflow || low_overflow;
  assign flags_ok = (low_zero == (result[NibW-1:0] == '0)) &&
                    (high_zero == (result[DataW-1:NibW] == '0)) &&
                    (low_sign == result[NibW-1]) && (high_sign == result[DataW-1]);

  `ALU8S_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")
  `ALU8S_ASSERT_NEXT(a_strobe_follows, cmd_xfer, ##1 done, "result strobe missing")
  `ALU8S_ASSERT_NOW(a_strobe_has_cmd, done, $past(cmd_xfer, 2), "strobe without a command")
  `ALU8S_ASSERT_NOW(a_flags_match, done, flags_ok, "zero or sign flag disagrees with result")
  `ALU8S_ASSERT_NOW(a_logic_no_ovf, done && $past(op_msb, 2), !any_ovf, "logic op overflow")

endmodule

bind alu_8bit_two_nibble_slices alu8s_checker u_checker (.*);

// ===== tb/tb_alu_8bit_two_nibble_slices.sv =====
// Testbench for the two-slice eight-bit ALU: checks every result against a slice-level predictor.
module tb_alu_8bit_two_nibble_slices;
  timeunit 1ns;
  timeprecision 1ps;

  import alu8s_pkg::*;

  localparam int unsigned RandomCmds = 400;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    opcode_t          op;
    logic             cin;
    logic             drain_first;
  } alu_cmd_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             high_carry;
    logic             high_zero;
    logic             high_sign;
    logic             high_overflow;
    logic             low_carry;
    logic             low_zero;
    logic             low_sign;
    logic             low_overflow;
  } alu_flags_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             done;
  logic [DataW-1:0] result;
  logic             high_carry;
  logic             high_zero;
  logic             high_sign;
  logic             high_overflow;
  logic             low_carry;
  logic             low_zero;
  logic             low_sign;
  logic             low_overflow;

  alu_cmd_t   cur_cmd = '0;
  alu_cmd_t   pending_cmds[$];
  alu_flags_t expected_results[$];
  logic       cmd_taken = 1'b0;
  int         mismatch_count = 0;
  int         results_seen = 0;
  int         total_cmds = 0;
  int         burst_left = 8;
  int         gap_left = 0;
  int         cycle_count = 0;

  alu_8bit_two_nibble_slices DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operand_a     (cur_cmd.a),
    .operand_b     (cur_cmd.b),
    .opcode        (cur_cmd.op),
    .carry         (cur_cmd.cin),
    .done          (done),
    .result        (result),
    .high_carry    (high_carry),
    .high_zero     (high_zero),
    .high_sign     (high_sign),
    .high_overflow (high_overflow),
    .low_carry     (low_carry),
    .low_zero      (low_zero),
    .low_sign      (low_sign),
    .low_overflow  (low_overflow)
  );

  function automatic slice_out_t eval_slice(input logic [NibW-1:0] a, input logic [NibW-1:0] b,
                                            input opcode_t op, input logic c,
                                            input logic is_low);
    logic [7:0] ax;
    logic [7:0] bx;
    logic [7:0] cx;
    logic [7:0] addend;
    logic [7:0] r;
    logic       of;
    slice_out_t s;
    ax = {4'b0, a};
    bx = {4'b0, b};
    cx = {7'b0, c};
    r  = 8'h00;
    of = 1'b0;
    case (op)
      OP_ADD, OP_ADC: begin
        r  = ax + bx + ((op == OP_ADD && is_low) ? 8'h00 : cx);
        of = (a[3] == b[3]) && (a[3] != r[3]);
      end
      OP_SUB, OP_SBC: begin
        addend = ~bx + 8'h01 - ((op == OP_SUB && is_low) ? 8'h00 : cx);
        r      = ax + addend;
        of     = (a[3] == addend[3]) && (a[3] != r[3]);
      end
      OP_NEG:         r = (~ax + (is_low ? 8'h01 : cx)) ^ 8'h10;
      OP_SHL, OP_SHLC: r = {ax[6:0], 1'b0} | ((op == OP_SHL && is_low) ? 8'h00 : cx);
      OP_INC: begin
        r  = ax + (is_low ? 8'h01 : cx);
        of = !a[3] && r[3];
      end
      OP_NOT:  r = ~ax;
      OP_AND:  r = ax & bx;
      OP_OR:   r = ax | bx;
      OP_XOR:  r = ax ^ bx;
      OP_ZERO: r = 8'h00;
      OP_TEST: begin
        if (is_low) begin
          r = (a != 4'h0 || c) ? 8'h01 : 8'h00;
        end else begin
          r = (a != 4'h0) ? 8'h10 : 8'h00;
        end
      end
      OP_SHR:  r = {3'b0, a[0], is_low & c, a[3:1]};
      OP_SHRC: r = {3'b0, a[0], c, a[3:1]};
      default: r = 8'h00;
    endcase
    s.nibble   = r[3:0];
    s.carry    = r[4];
    s.overflow = of;
    return s;
  endfunction

  function automatic alu_flags_t predict_alu(input alu_cmd_t cmd);
    slice_out_t lo;
    slice_out_t hi;
    alu_flags_t f;
    if (!cmd.op[3]) begin
      lo = eval_slice(cmd.a[3:0], cmd.b[3:0], cmd.op, cmd.cin, 1'b1);
      hi = eval_slice(cmd.a[7:4], cmd.b[7:4], cmd.op, lo.carry, 1'b0);
    end else begin
      hi = eval_slice(cmd.a[7:4], cmd.b[7:4], cmd.op, cmd.cin, 1'b0);
      lo = eval_slice(cmd.a[3:0], cmd.b[3:0], cmd.op, hi.carry, 1'b1);
    end
    f.result        = {hi.nibble, lo.nibble};
    f.high_carry    = hi.carry;
    f.high_zero     = (hi.nibble == 4'h0);
    f.high_sign     = hi.nibble[3];
    f.high_overflow = hi.overflow;
    f.low_carry     = lo.carry;
    f.low_zero      = (lo.nibble == 4'h0);
    f.low_sign      = lo.nibble[3];
    f.low_overflow  = lo.overflow;
    return f;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] corners[4];
    corners = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 3)];
    end
    return DataW'($urandom());
  endfunction

  task automatic add_cmd(input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                         input opcode_t op, input logic cin, input logic drain_first);
    alu_cmd_t cmd;
    cmd.a           = a;
    cmd.b           = b;
    cmd.op          = op;
    cmd.cin         = cin;
    cmd.drain_first = drain_first;
    pending_cmds.push_back(cmd);
  endtask

  task automatic compare_field(input string name, input logic [DataW-1:0] want,
                               input logic [DataW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_results.size());
      $display("tb_alu_8bit_two_nibble_slices: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin : driver
    logic next_start;
    next_start = 1'b0;
    if (rst) begin
      next_start = 1'b0;
    end else if (start && !cmd_taken) begin
      next_start = 1'b1;
    end else begin
      cmd_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
        cur_cmd <= pending_cmds.pop_front();
        next_start = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    start <= next_start;
  end

  always @(posedge clk) begin : monitor
    alu_flags_t want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result %h with no transfer outstanding, expected none",
                   $time, result);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("result", want.result, result);
          compare_field("high_carry", want.high_carry, high_carry);
          compare_field("high_zero", want.high_zero, high_zero);
          compare_field("high_sign", want.high_sign, high_sign);
          compare_field("high_overflow", want.high_overflow, high_overflow);
          compare_field("low_carry", want.low_carry, low_carry);
          compare_field("low_zero", want.low_zero, low_zero);
          compare_field("low_sign", want.low_sign, low_sign);
          compare_field("low_overflow", want.low_overflow, low_overflow);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_alu(cur_cmd));
        cmd_taken = 1'b1;
      end
    end
  end

  initial begin : sequencer
    logic [3:0] op_bits;
    for (int i = 0; i < 16; i++) begin
      op_bits = 4'(i);
      add_cmd(op_bits[0] ? 8'h00 : 8'hFF, op_bits[0] ? 8'hFF : 8'h00, opcode_t'(op_bits),
              op_bits[0] ^ op_bits[1], 1'b0);
    end
    add_cmd(8'h77, 8'h11, OP_ADD, 1'b0, 1'b0);
    add_cmd(8'h80, 8'h01, OP_SUB, 1'b0, 1'b0);
    add_cmd(8'h7F, 8'h00, OP_INC, 1'b1, 1'b0);
    add_cmd(8'h00, 8'h00, OP_NEG, 1'b1, 1'b0);
    add_cmd(8'h00, 8'h00, OP_TEST, 1'b1, 1'b0);
    add_cmd(8'h00, 8'h00, OP_TEST, 1'b0, 1'b0);
    add_cmd(8'hF0, 8'h00, OP_TEST, 1'b0, 1'b0);
    add_cmd(8'h01, 8'hFF, OP_SBC, 1'b1, 1'b0);
    add_cmd(8'h81, 8'h00, OP_SHRC, 1'b1, 1'b0);
    for (int i = 0; i < RandomCmds; i++) begin
      add_cmd(pick_operand(), pick_operand(), opcode_t'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)), (i == 0) || (i == RandomCmds / 2));
    end
    total_cmds = pending_cmds.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (results_seen < total_cmds) @(posedge clk);
    repeat (6) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d results expected, 0 arrived", $time, expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_alu_8bit_two_nibble_slices: PASS");
    end else begin
      $display("tb_alu_8bit_two_nibble_slices: FAIL");
    end
    $finish;
  end

endmodule
